// ===== hw/rtl/hfu_pkg.sv =====
// Shared types and constants for the RTP HEVC fragmentation-unit depacketizer.
// Used by hfu_parser, hfu_result_fifo and rtp_hevc_fu_depacketizer; no dependencies.
package hfu_pkg;

  // Most results one payload byte can produce (two data bytes plus a status)
  localparam int MAX_RESULTS = 3;
  // Default depth of the result queue; a power of two, at least 4
  localparam int FIFO_DEPTH_DEF = 4;

  // NAL unit type codes from the payload header
  localparam logic [5:0] TYPE_SINGLE_LIMIT = 6'd48;  // types 1..47 are single NAL units
  localparam logic [5:0] TYPE_FU           = 6'd49;
  localparam logic [5:0] TYPE_NONE         = 6'd0;

  // End-of-packet status; NEED_MORE also means "no error" in the error register
  typedef enum logic [2:0] {
    ST_NEED_MORE   = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_NO_START    = 3'd2,
    ST_SHORT       = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_UNKNOWN  = 2'd0,
    CLS_SINGLE   = 2'd1,
    CLS_FU       = 2'd2,
    CLS_REJECTED = 2'd3
  } pkt_class_t;

  // Byte position inside the packet, saturating at the payload position
  typedef enum logic [1:0] {
    POS_HDR0    = 2'd0,
    POS_HDR1    = 2'd1,
    POS_FU_HDR  = 2'd2,
    POS_PAYLOAD = 2'd3
  } pos_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] nal_byte;
    logic       nal_end;
    status_t    status;
    logic       run_last;
  } result_t;

endpackage

// ===== hw/rtl/rtp_hevc_fu_depacketizer.sv =====
// Top level of the RTP HEVC depacketizer: single NAL units and fragmentation units.
// Instantiates hfu_parser and hfu_result_fifo; depends on hfu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one RTP payload byte per transaction,
//   in_packet_last high on the final byte of each payload.
//   Output channel (out_valid / out_stall): one result per transaction, either a
//   reassembled NAL byte (out_result_kind = 0) or an end-of-packet status
//   (out_result_kind = 1). out_run_last marks the last result of an input byte.
//   Each byte gives zero to three results; payload bytes of a single NAL or
//   FU packet without error give one data result each and stream at one byte
//   per cycle while in_stall stays low. The output moves one result per cycle
//   while out_stall stays low. Header bytes are held back and released
//   together with the second (or FU header) byte.
//   Accepted results are registered in the result queue and offered from its head.
//   The result queue holds FIFO_DEPTH entries; in_stall rises while fewer than
//   three entries are free, so a stalled receiver backs up into the input
//   and nothing is dropped.
//   Reset (rst_n low, synchronous) empties the queue and clears packet and
//   fragment state; the next byte is taken as byte 0 of a packet.
module rtp_hevc_fu_depacketizer #(
  parameter int FIFO_DEPTH = hfu_pkg::FIFO_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_packet_byte,
  input  logic                    in_packet_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_result_kind,
  output logic [7:0]              out_nal_byte,
  output logic                    out_nal_end,
  output logic [2:0]              out_packet_status,
  output logic                    out_run_last
);
  import hfu_pkg::*;

  result_t [MAX_RESULTS-1:0] step_res;
  res_cnt_t                  step_cnt;
  result_t                   head;
  logic                      space;
  logic                      step_en;

  // Input transaction accept
  assign in_stall = !space;
  assign step_en  = in_valid && space;

  hfu_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .packet_byte (in_packet_byte),
    .packet_last (in_packet_last),
    .res         (step_res),
    .res_cnt     (step_cnt)
  );

  hfu_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_en),
    .wr_res    (step_res),
    .wr_cnt    (step_cnt),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head)
  );

  // Result fields
  assign out_result_kind   = head.kind;
  assign out_nal_byte      = head.nal_byte;
  assign out_nal_end       = head.nal_end;
  assign out_packet_status = head.status;
  assign out_run_last      = head.run_last;

endmodule

// ===== hw/rtl/hfu_parser.sv =====
// Payload parser: tracks packet position, header bytes and fragment state,
// and forms the up to three results of each accepted byte. Depends on hfu_pkg.
module hfu_parser (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              step_en,
  input  logic [7:0]                                        packet_byte,
  input  logic                                              packet_last,
  output hfu_pkg::result_t [hfu_pkg::MAX_RESULTS-1:0]       res,
  output hfu_pkg::res_cnt_t                                 res_cnt
);
  import hfu_pkg::*;

  pos_t       pos_r, pos_nxt;
  logic [7:0] hdr0_r, hdr0_nxt;
  logic [7:0] hdr1_r, hdr1_nxt;
  pkt_class_t cls_r, cls_nxt;
  logic       frag_active_r, frag_active_nxt;
  logic       frag_end_r, frag_end_nxt;
  status_t    err_r, err_nxt;

  logic [5:0] nal_type;
  logic [7:0] data [2];
  res_cnt_t   ndata;
  status_t    status;

  assign nal_type = packet_byte[6:1];

  // Next state and data bytes for this byte
  always_comb begin
    pos_nxt         = pos_r;
    hdr0_nxt        = hdr0_r;
    hdr1_nxt        = hdr1_r;
    cls_nxt         = cls_r;
    frag_active_nxt = frag_active_r;
    frag_end_nxt    = frag_end_r;
    err_nxt         = err_r;
    data[0]         = '0;
    data[1]         = '0;
    ndata           = '0;
    status          = ST_NEED_MORE;

    unique case (pos_r)
      POS_HDR0: begin
        hdr0_nxt     = packet_byte;
        err_nxt      = ST_NEED_MORE;
        frag_end_nxt = 1'b0;
        priority if (nal_type != TYPE_NONE && nal_type < TYPE_SINGLE_LIMIT) begin
          cls_nxt = CLS_SINGLE;
        end else if (nal_type == TYPE_FU) begin
          cls_nxt = CLS_FU;
        end else begin
          cls_nxt = CLS_REJECTED;
          err_nxt = ST_UNSUPPORTED;
        end
      end
      POS_HDR1: begin
        hdr1_nxt = packet_byte;
        if (cls_r == CLS_SINGLE) begin
          // single NAL: release the held header, abandoning any fragment
          frag_active_nxt = 1'b0;
          data[0]         = hdr0_r;
          data[1]         = packet_byte;
          ndata           = 2'd2;
        end
      end
      POS_FU_HDR, POS_PAYLOAD: begin
        priority if (cls_r == CLS_SINGLE) begin
          data[0] = packet_byte;
          ndata   = 2'd1;
        end else if (cls_r == CLS_FU && err_r == ST_NEED_MORE) begin
          if (pos_r == POS_FU_HDR) begin
            frag_end_nxt = packet_byte[6];
            priority if (packet_byte[7]) begin
              // start fragment: rebuild the header with the original type
              frag_active_nxt = 1'b1;
              data[0]         = {hdr0_r[7], packet_byte[5:0], hdr0_r[0]};
              data[1]         = hdr1_r;
              ndata           = 2'd2;
            end else if (!frag_active_r) begin
              err_nxt = ST_NO_START;
            end else begin
              // continuation of an open fragment: header gives no data
            end
          end else begin
            data[0] = packet_byte;
            ndata   = 2'd1;
          end
        end else begin
          // rejected or failed packet: the rest is dropped
        end
      end
      default: ;
    endcase

    if (pos_r != POS_PAYLOAD) begin
      pos_nxt = pos_t'(2'(pos_r + 2'd1));
    end

    // End-of-packet status, from the state after this byte
    priority if (pos_r == POS_HDR0) begin
      status = ST_SHORT;
    end else if (cls_nxt == CLS_FU && pos_r == POS_HDR1) begin
      status = ST_SHORT;
    end else if (err_nxt != ST_NEED_MORE) begin
      status = err_nxt;
    end else if (cls_nxt == CLS_SINGLE) begin
      status = ST_COMPLETE;
    end else begin
      status = frag_end_nxt ? ST_COMPLETE : ST_NEED_MORE;
    end

    if (packet_last) begin
      if (status == ST_COMPLETE && cls_nxt == CLS_FU) begin
        frag_active_nxt = 1'b0;
      end
      pos_nxt      = POS_HDR0;
      cls_nxt      = CLS_UNKNOWN;
      err_nxt      = ST_NEED_MORE;
      frag_end_nxt = 1'b0;
    end
  end

  // Result assembly: data bytes first, then the status on the last byte
  assign res_cnt = res_cnt_t'(ndata + res_cnt_t'(packet_last));

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
      if (res_cnt_t'(k) < ndata) begin
        res[k].kind     = KIND_DATA;
        res[k].nal_byte = (k == 0) ? data[0] : data[1];
        res[k].nal_end  = packet_last && status == ST_COMPLETE &&
                          res_cnt_t'(k + 1) == ndata;
      end else if (res_cnt_t'(k) == ndata && packet_last) begin
        res[k].kind   = KIND_STATUS;
        res[k].status = status;
      end
      res[k].run_last = res_cnt_t'(k + 1) == res_cnt;
    end
  end

  // Packet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= POS_HDR0;
      hdr0_r        <= '0;
      hdr1_r        <= '0;
      cls_r         <= CLS_UNKNOWN;
      frag_active_r <= 1'b0;
      frag_end_r    <= 1'b0;
      err_r         <= ST_NEED_MORE;
    end else if (step_en) begin
      pos_r         <= pos_nxt;
      hdr0_r        <= hdr0_nxt;
      hdr1_r        <= hdr1_nxt;
      cls_r         <= cls_nxt;
      frag_active_r <= frag_active_nxt;
      frag_end_r    <= frag_end_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

// ===== hw/rtl/hfu_result_fifo.sv =====
// Result queue: takes up to three results per cycle, hands out one per transaction.
// Depends on hfu_pkg.
module hfu_result_fifo #(
  parameter int DEPTH = hfu_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         push,
  input  hfu_pkg::result_t [hfu_pkg::MAX_RESULTS-1:0]  wr_res,
  input  hfu_pkg::res_cnt_t                            wr_cnt,
  output logic                                         space,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output hfu_pkg::result_t                             out_res
);
  import hfu_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] wr_n;
  logic            pop;

  assign pop       = out_valid && !out_stall;
  assign wr_n      = push ? CntW'(wr_cnt) : '0;
  assign count_nxt = CntW'(count_r + wr_n - CntW'(pop));
  assign space     = count_r <= CntW'(DEPTH - MAX_RESULTS);
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (push && res_cnt_t'(k) < wr_cnt) begin
        mem_r[wr_ptr_r + PtrW'(k)] <= wr_res[k];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= PtrW'(wr_ptr_r + PtrW'(wr_n));
      rd_ptr_r <= PtrW'(rd_ptr_r + PtrW'(pop));
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("result queue fill level above depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r <= CntW'(DEPTH - MAX_RESULTS))
    else $error("results pushed without room for a full run");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == CntW'($past(count_r) - 1'b1))
    else $error("fill level did not drop on a lone read");

endmodule
